@@ rtl/bht_pkg.sv @@
`timescale 1ns / 1ps
package bht_pkg;

    localparam int TABLE_ENTRIES   = 64;
    localparam int HANDLER_SLOTS   = 4;
    localparam int ADDRESS_BITS    = 16;
    localparam int HANDLER_ID_BITS = 8;

    localparam int OP_W   = 2;
    localparam int ADDR_W = 16;
    localparam int ID_W   = 8;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_CHECK  = 2'd2;

endpackage

@@ rtl/bht_if.sv @@
`timescale 1ns / 1ps
interface bht_req_if;
    logic                      valid;
    logic                      ready;
    logic [bht_pkg::OP_W-1:0]   operation;
    logic [bht_pkg::ADDR_W-1:0] address;
    logic                      all_addresses;
    logic [bht_pkg::ID_W-1:0]   handler_function;
    logic [bht_pkg::ID_W-1:0]   handler_context;

    modport source (output valid, operation, address, all_addresses,
                    handler_function, handler_context, input ready);
    modport sink (input valid, operation, address, all_addresses,
                  handler_function, handler_context, output ready);
endinterface

interface bht_rsp_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic                    ok;
    logic [bht_pkg::ID_W-1:0] hit_function;
    logic [bht_pkg::ID_W-1:0] hit_context;
    logic                    last;

    modport source (output valid, kind, ok, hit_function, hit_context, last,
                    input ready);
    modport sink (input valid, kind, ok, hit_function, hit_context, last,
                  output ready);
endinterface

@@ rtl/bht_slot_mem.sv @@
`timescale 1ns / 1ps
// One row per entry: address plus all handler slots, registered read.
module bht_slot_mem #(
    parameter int ENTRIES = 64,
    parameter int ROW_W   = 80
) (
    input  logic                       clk,
    input  logic [$clog2(ENTRIES)-1:0] rd_idx,
    output logic [ROW_W-1:0]           rd_data,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_idx,
    input  logic [ROW_W-1:0]           wr_data
);
    logic [ROW_W-1:0] mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        rd_data <= mem[rd_idx];
    end
endmodule

@@ rtl/breakpoint_handler_table.sv @@
`timescale 1ns / 1ps
// Sequence: every add, remove or check sweeps all entries, one row per cycle.
// After the sweep, remove loads its result in S_OUT; add passes S_WAIT (on a hit)
// and S_MOD, then loads it in S_OUT; check passes S_WAIT (on a hit) and S_MOD, then
// S_EMIT loads one result per filled slot, skipping empty ones. One request at a time:
// the next is taken the cycle after the last result is loaded; output stalls delay it.
// Reset: entry valid bits clear at once; row contents are undefined until written.
module breakpoint_handler_table #(
    parameter int TABLE_ENTRIES   = bht_pkg::TABLE_ENTRIES,
    parameter int HANDLER_SLOTS   = bht_pkg::HANDLER_SLOTS,
    parameter int ADDRESS_BITS    = bht_pkg::ADDRESS_BITS,
    parameter int HANDLER_ID_BITS = bht_pkg::HANDLER_ID_BITS
) (
    input logic clk,
    input logic rst_n,
    bht_req_if.sink   req,
    bht_rsp_if.source rsp
);
    localparam int EW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SW    = (HANDLER_SLOTS > 1) ? $clog2(HANDLER_SLOTS) : 1;
    localparam int HW    = 2 * HANDLER_ID_BITS;
    localparam int ROW_W = ADDRESS_BITS + HANDLER_SLOTS * HW;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WAIT, S_MOD, S_EMIT, S_OUT} state_t;

    state_t state_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [EW:0] idx_reg;
    logic [EW-1:0] hit_idx_reg, free_idx_reg;
    logic found_reg, free_reg, scanned_reg;
    logic [1:0] op_reg;
    logic all_reg;
    logic [ADDRESS_BITS-1:0] addr_reg;
    logic [HANDLER_ID_BITS-1:0] fn_reg, cx_reg;
    logic [ROW_W-1:0] row_reg;
    logic [SW:0] slot_reg;
    logic out_valid_reg, ok_reg, last_reg;
    logic [1:0] kind_reg;
    logic [bht_pkg::ID_W-1:0] hf_reg, hc_reg;

    logic [EW-1:0] rd_idx, wr_idx;
    logic [ROW_W-1:0] rd_data, wr_data;
    logic wr_en;

    bht_slot_mem #(.ENTRIES(TABLE_ENTRIES), .ROW_W(ROW_W)) u_mem (
        .clk(clk), .rd_idx(rd_idx), .rd_data(rd_data),
        .wr_en(wr_en), .wr_idx(wr_idx), .wr_data(wr_data)
    );

    // rd_data belongs to entry idx_reg-1 while scanning
    logic [EW-1:0] prev_idx;
    logic [ADDRESS_BITS-1:0] row_addr;
    logic row_live;
    logic row_hit;
    assign prev_idx = EW'(idx_reg - 1'b1);
    assign row_addr = rd_data[ROW_W-1 -: ADDRESS_BITS];
    assign row_live = scanned_reg && valid_reg[prev_idx];
    assign row_hit  = row_live && row_addr == addr_reg;

    function automatic logic [HANDLER_ID_BITS-1:0] sfn(input logic [ROW_W-1:0] r,
                                                       input int s);
        return r[s*HW + HANDLER_ID_BITS +: HANDLER_ID_BITS];
    endfunction
    function automatic logic [HANDLER_ID_BITS-1:0] scx(input logic [ROW_W-1:0] r,
                                                       input int s);
        return r[s*HW +: HANDLER_ID_BITS];
    endfunction

    // remove: modified row and whether any slot survives
    logic [ROW_W-1:0] rm_row;
    logic rm_left;
    always_comb
    begin
        rm_row  = rd_data;
        rm_left = 1'b0;
        for (int s = 0; s < HANDLER_SLOTS; s++)
        begin
            if (sfn(rd_data, s) != '0)
            begin
                if ((fn_reg == '0 || fn_reg == sfn(rd_data, s)) &&
                    (cx_reg == '0 || cx_reg == scx(rd_data, s)))
                begin
                    rm_row[s*HW + HANDLER_ID_BITS +: HANDLER_ID_BITS] = '0;
                end
                else
                begin
                    rm_left = 1'b1;
                end
            end
        end
    end

    // add on existing row: the row arrives on rd_data in S_MOD, then sits in row_reg
    logic [ROW_W-1:0] add_src;
    assign add_src = (state_reg == S_MOD) ? rd_data : row_reg;

    logic add_dup, add_free;
    logic [ROW_W-1:0] add_row;
    always_comb
    begin
        add_dup  = 1'b0;
        add_free = 1'b0;
        add_row  = add_src;
        for (int s = 0; s < HANDLER_SLOTS; s++)
        begin
            if (sfn(add_src, s) == fn_reg && scx(add_src, s) == cx_reg)
            begin
                add_dup = 1'b1;
            end
        end
        for (int s = 0; s < HANDLER_SLOTS; s++)
        begin
            if (!add_free && sfn(add_src, s) == '0)
            begin
                add_free = 1'b1;
                add_row[s*HW +: HW] = {fn_reg, cx_reg};
            end
        end
    end

    logic [ROW_W-1:0] new_row;
    always_comb
    begin
        new_row = '0;
        new_row[ROW_W-1 -: ADDRESS_BITS] = addr_reg;
        new_row[HW-1:0] = {fn_reg, cx_reg};
    end

    logic scan_done;
    assign scan_done = (idx_reg == (EW+1)'(TABLE_ENTRIES));
    logic cur_fn_nz;
    logic [SW-1:0] slot_i;
    assign slot_i    = slot_reg[SW-1:0];
    assign cur_fn_nz = sfn(row_reg, 32'(slot_i)) != '0;
    logic later_nz;
    always_comb
    begin
        later_nz = 1'b0;
        for (int s = 0; s < HANDLER_SLOTS; s++)
        begin
            if (s > 32'(slot_i) && sfn(row_reg, s) != '0)
            begin
                later_nz = 1'b1;
            end
        end
    end

    // output register is reloaded this cycle
    logic out_load;
    always_comb
    begin
        out_load = 1'b0;
        if ((state_reg == S_EMIT && (slot_reg == (SW+1)'(HANDLER_SLOTS) || cur_fn_nz)) ||
            state_reg == S_OUT)
        begin
            out_load = !out_valid_reg || rsp.ready;
        end
    end

    always_comb
    begin
        rd_idx  = idx_reg[EW-1:0];
        wr_en   = 1'b0;
        wr_idx  = prev_idx;
        wr_data = rm_row;
        if (state_reg == S_SCAN && op_reg == bht_pkg::OP_REMOVE && row_live &&
            (all_reg || row_addr == addr_reg))
        begin
            wr_en = 1'b1;
        end
        if (state_reg == S_MOD)
        begin
            wr_idx = found_reg ? hit_idx_reg : free_idx_reg;
            if (found_reg)
            begin
                wr_en   = !add_dup && add_free && op_reg == bht_pkg::OP_ADD;
                wr_data = add_row;
            end
            else
            begin
                wr_en   = free_reg && op_reg == bht_pkg::OP_ADD;
                wr_data = new_row;
            end
        end
        if (state_reg == S_WAIT)
        begin
            rd_idx = hit_idx_reg;
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.kind         = kind_reg;
    assign rsp.ok           = ok_reg;
    assign rsp.hit_function = hf_reg;
    assign rsp.hit_context  = hc_reg;
    assign rsp.last         = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            scanned_reg   <= 1'b0;
            found_reg     <= 1'b0;
            free_reg      <= 1'b0;
            hit_idx_reg   <= '0;
            free_idx_reg  <= '0;
            slot_reg      <= '0;
        end
        else
        begin
            if (out_valid_reg && rsp.ready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid && req.operation != bht_pkg::OP_UNUSED)
                    begin
                        op_reg      <= req.operation;
                        all_reg     <= req.all_addresses;
                        addr_reg    <= req.address[ADDRESS_BITS-1:0];
                        fn_reg      <= HANDLER_ID_BITS'(req.handler_function);
                        cx_reg      <= HANDLER_ID_BITS'(req.handler_context);
                        idx_reg     <= '0;
                        scanned_reg <= 1'b0;
                        found_reg   <= 1'b0;
                        free_reg    <= 1'b0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    scanned_reg <= 1'b1;
                    if (!scan_done)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (row_hit && !found_reg)
                    begin
                        found_reg   <= 1'b1;
                        hit_idx_reg <= prev_idx;
                    end
                    if (scanned_reg && !valid_reg[prev_idx] && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= prev_idx;
                    end
                    if (op_reg == bht_pkg::OP_REMOVE && row_live &&
                        (all_reg || row_addr == addr_reg) && !rm_left)
                    begin
                        valid_reg[prev_idx] <= 1'b0;
                    end
                    if (scan_done)
                    begin
                        if (op_reg == bht_pkg::OP_REMOVE)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= (found_reg || row_hit) ? S_WAIT : S_MOD;
                        end
                    end
                end
                S_WAIT:
                begin
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    slot_reg <= '0;
                    if (op_reg == bht_pkg::OP_CHECK)
                    begin
                        state_reg <= S_EMIT;
                        if (!found_reg)
                        begin
                            row_reg <= '0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                        if (!found_reg && free_reg)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        if (slot_reg == (SW+1)'(HANDLER_SLOTS))
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= bht_pkg::KIND_CHECK;
                            ok_reg        <= 1'b0;
                            hf_reg        <= '0;
                            hc_reg        <= '0;
                            last_reg      <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                        else if (cur_fn_nz)
                        begin
                            out_valid_reg <= 1'b1;
                            kind_reg      <= bht_pkg::KIND_CHECK;
                            ok_reg        <= 1'b1;
                            hf_reg        <= bht_pkg::ID_W'(sfn(row_reg, 32'(slot_i)));
                            hc_reg        <= bht_pkg::ID_W'(scx(row_reg, 32'(slot_i)));
                            last_reg      <= !later_nz;
                            slot_reg      <= slot_reg + 1'b1;
                            if (!later_nz)
                            begin
                                state_reg <= S_IDLE;
                            end
                        end
                        else
                        begin
                            slot_reg <= slot_reg + 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        kind_reg      <= (op_reg == bht_pkg::OP_ADD) ?
                                         bht_pkg::KIND_ADD : bht_pkg::KIND_REMOVE;
                        ok_reg        <= (op_reg == bht_pkg::OP_ADD) &&
                                         (found_reg ? (add_dup || add_free) : free_reg);
                        hf_reg        <= '0;
                        hc_reg        <= '0;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            if (state_reg == S_WAIT)
            begin
                scanned_reg <= 1'b0;
            end
            if (state_reg == S_MOD && found_reg)
            begin
                row_reg <= rd_data;
            end
        end
    end
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
module tb;

    typedef struct packed {
        logic [1:0]               kind;
        logic                     ok;
        logic [bht_pkg::ID_W-1:0] hit_function;
        logic [bht_pkg::ID_W-1:0] hit_context;
        logic                     last;
    } bht_result_t;

    logic clk;
    logic rst_n;
    int   errors;
    int   stall_left;

    bht_req_if req_ch();
    bht_rsp_if rsp_ch();

    breakpoint_handler_table uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    bit                         mdl_valid [bht_pkg::TABLE_ENTRIES];
    logic [bht_pkg::ADDR_W-1:0] mdl_addr  [bht_pkg::TABLE_ENTRIES];
    logic [bht_pkg::ID_W-1:0]   mdl_fn    [bht_pkg::TABLE_ENTRIES][bht_pkg::HANDLER_SLOTS];
    logic [bht_pkg::ID_W-1:0]   mdl_cx    [bht_pkg::TABLE_ENTRIES][bht_pkg::HANDLER_SLOTS];
    bht_result_t                pending_results[$];

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int find_entry(logic [bht_pkg::ADDR_W-1:0] a);
        for (int e = 0; e < bht_pkg::TABLE_ENTRIES; e++)
        begin
            if (mdl_valid[e] && mdl_addr[e] == a)
                return e;
        end
        return -1;
    endfunction

    function automatic bit table_add(logic [bht_pkg::ADDR_W-1:0] a,
                                     logic [bht_pkg::ID_W-1:0] fn,
                                     logic [bht_pkg::ID_W-1:0] cx);
        int e;
        e = find_entry(a);
        if (e < 0)
        begin
            for (e = 0; e < bht_pkg::TABLE_ENTRIES; e++)
            begin
                if (!mdl_valid[e])
                    break;
            end
            if (e >= bht_pkg::TABLE_ENTRIES)
                return 1'b0;
            mdl_valid[e] = 1'b1;
            mdl_addr[e]  = a;
            for (int s = 0; s < bht_pkg::HANDLER_SLOTS; s++)
            begin
                mdl_fn[e][s] = '0;
                mdl_cx[e][s] = '0;
            end
            mdl_fn[e][0] = fn;
            mdl_cx[e][0] = cx;
            return 1'b1;
        end
        for (int s = 0; s < bht_pkg::HANDLER_SLOTS; s++)
        begin
            if (mdl_fn[e][s] == fn && mdl_cx[e][s] == cx)
                return 1'b1;
        end
        for (int s = 0; s < bht_pkg::HANDLER_SLOTS; s++)
        begin
            if (mdl_fn[e][s] == '0)
            begin
                mdl_fn[e][s] = fn;
                mdl_cx[e][s] = cx;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void table_remove(logic [bht_pkg::ADDR_W-1:0] a, logic all,
                                         logic [bht_pkg::ID_W-1:0] fn,
                                         logic [bht_pkg::ID_W-1:0] cx);
        int left;
        for (int e = 0; e < bht_pkg::TABLE_ENTRIES; e++)
        begin
            left = 0;
            if (!mdl_valid[e] || (!all && mdl_addr[e] != a))
                continue;
            for (int s = 0; s < bht_pkg::HANDLER_SLOTS; s++)
            begin
                if (mdl_fn[e][s] == '0)
                    continue;
                if ((fn == '0 || fn == mdl_fn[e][s]) && (cx == '0 || cx == mdl_cx[e][s]))
                    mdl_fn[e][s] = '0;
                else
                    left++;
            end
            if (left == 0)
                mdl_valid[e] = 1'b0;
        end
    endfunction

    function automatic void predict_results(logic [1:0] op, logic [bht_pkg::ADDR_W-1:0] a,
                                            logic all, logic [bht_pkg::ID_W-1:0] fn,
                                            logic [bht_pkg::ID_W-1:0] cx);
        bht_result_t r;
        int e;
        int n;
        r = '0;
        r.last = 1'b1;
        if (op == bht_pkg::OP_ADD)
        begin
            r.kind = bht_pkg::KIND_ADD;
            r.ok   = table_add(a, fn, cx);
            pending_results.push_back(r);
        end
        else if (op == bht_pkg::OP_REMOVE)
        begin
            table_remove(a, all, fn, cx);
            r.kind = bht_pkg::KIND_REMOVE;
            pending_results.push_back(r);
        end
        else if (op == bht_pkg::OP_CHECK)
        begin
            n = 0;
            e = find_entry(a);
            r.kind = bht_pkg::KIND_CHECK;
            if (e >= 0)
            begin
                for (int s = 0; s < bht_pkg::HANDLER_SLOTS; s++)
                begin
                    if (mdl_fn[e][s] != '0)
                    begin
                        r.ok           = 1'b1;
                        r.hit_function = mdl_fn[e][s];
                        r.hit_context  = mdl_cx[e][s];
                        r.last         = 1'b0;
                        pending_results.push_back(r);
                        n++;
                    end
                end
            end
            if (n == 0)
            begin
                r = '0;
                r.kind = bht_pkg::KIND_CHECK;
                r.last = 1'b1;
                pending_results.push_back(r);
            end
            else
                pending_results[$].last = 1'b1;
        end
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(logic [1:0] op, logic [bht_pkg::ADDR_W-1:0] a, logic all,
                                logic [bht_pkg::ID_W-1:0] fn, logic [bht_pkg::ID_W-1:0] cx);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.operation        <= op;
        req_ch.address          <= a;
        req_ch.all_addresses    <= all;
        req_ch.handler_function <= fn;
        req_ch.handler_context  <= cx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predict_results(op, a, all, fn, cx);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
        end
    end

    always @(posedge clk)
    begin
        bht_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result kind=%0d", rsp_ch.kind);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, rsp_ch.kind);
                    errors++;
                end
                if (rsp_ch.ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, rsp_ch.ok);
                    errors++;
                end
                if (rsp_ch.hit_function !== want.hit_function)
                begin
                    $error("hit_function: expected %0h, got %0h",
                           want.hit_function, rsp_ch.hit_function);
                    errors++;
                end
                if (rsp_ch.hit_context !== want.hit_context)
                begin
                    $error("hit_context: expected %0h, got %0h",
                           want.hit_context, rsp_ch.hit_context);
                    errors++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, rsp_ch.last);
                    errors++;
                end
            end
        end
    end

    task automatic test_basic();
        send_request(bht_pkg::OP_CHECK, 16'h0000, 1'b0, 8'h00, 8'h00);
        send_request(bht_pkg::OP_ADD, 16'h0000, 1'b0, 8'hFF, 8'hFF);
        send_request(bht_pkg::OP_ADD, 16'hFFFF, 1'b1, 8'h01, 8'h00);
        send_request(bht_pkg::OP_CHECK, 16'h0000, 1'b0, 8'h00, 8'h00);
        send_request(bht_pkg::OP_CHECK, 16'hFFFF, 1'b1, 8'hFF, 8'hFF);
        send_request(bht_pkg::OP_ADD, 16'h0000, 1'b0, 8'hFF, 8'hFF);
        send_request(bht_pkg::OP_UNUSED, 16'hFFFF, 1'b1, 8'hFF, 8'hFF);
    endtask

    task automatic test_slots();
        // fill all four slots, overflow, and a zero-function add
        send_request(bht_pkg::OP_ADD, 16'h1234, 1'b0, 8'h10, 8'h01);
        send_request(bht_pkg::OP_ADD, 16'h1234, 1'b0, 8'h20, 8'h02);
        send_request(bht_pkg::OP_ADD, 16'h1234, 1'b0, 8'h30, 8'h03);
        send_request(bht_pkg::OP_ADD, 16'h1234, 1'b0, 8'h40, 8'h04);
        send_request(bht_pkg::OP_ADD, 16'h1234, 1'b0, 8'h50, 8'h05);
        send_request(bht_pkg::OP_CHECK, 16'h1234, 1'b0, 8'h00, 8'h00);
        send_request(bht_pkg::OP_ADD, 16'h5555, 1'b0, 8'h00, 8'h07);
        send_request(bht_pkg::OP_CHECK, 16'h5555, 1'b0, 8'h00, 8'h00);
        send_request(bht_pkg::OP_ADD, 16'h5555, 1'b0, 8'h00, 8'h07);
    endtask

    task automatic test_remove();
        send_request(bht_pkg::OP_REMOVE, 16'h1234, 1'b0, 8'h20, 8'h00);
        send_request(bht_pkg::OP_REMOVE, 16'h1234, 1'b0, 8'h00, 8'h03);
        send_request(bht_pkg::OP_CHECK, 16'h1234, 1'b0, 8'h00, 8'h00);
        send_request(bht_pkg::OP_ADD, 16'h1234, 1'b0, 8'h00, 8'h03);
        send_request(bht_pkg::OP_REMOVE, 16'h1234, 1'b0, 8'h10, 8'h09);
        send_request(bht_pkg::OP_REMOVE, 16'h0000, 1'b1, 8'h00, 8'h00);
        send_request(bht_pkg::OP_CHECK, 16'h1234, 1'b0, 8'h00, 8'h00);
        send_request(bht_pkg::OP_CHECK, 16'h5555, 1'b0, 8'h00, 8'h00);
    endtask

    task automatic test_full_table();
        for (int i = 0; i < bht_pkg::TABLE_ENTRIES; i++)
            send_request(bht_pkg::OP_ADD, 16'(i * 997 + 3), 1'b0, 8'(i + 1), 8'(i));
        send_request(bht_pkg::OP_ADD, 16'hBEEF, 1'b0, 8'h01, 8'h01);
        send_request(bht_pkg::OP_CHECK, 16'h0003, 1'b0, 8'h00, 8'h00);
        send_request(bht_pkg::OP_REMOVE, 16'h0000, 1'b1, 8'h00, 8'h00);
    endtask

    task automatic test_random(int count);
        logic [bht_pkg::ADDR_W-1:0] addr_pool[8];
        logic [1:0]                 op;
        logic [bht_pkg::ADDR_W-1:0] a;
        logic                       all;
        logic [bht_pkg::ID_W-1:0]   fn;
        logic [bht_pkg::ID_W-1:0]   cx;
        int                         p;
        for (int i = 0; i < 8; i++)
            addr_pool[i] = 16'($urandom);
        addr_pool[0] = 16'hFFFF;
        addr_pool[1] = 16'h0000;
        for (int i = 0; i < count; i++)
        begin
            p   = $urandom_range(0, 99);
            op  = (p < 45) ? bht_pkg::OP_CHECK : (p < 78) ? bht_pkg::OP_ADD :
                  (p < 96) ? bht_pkg::OP_REMOVE : bht_pkg::OP_UNUSED;
            a   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : addr_pool[$urandom_range(0, 7)];
            all = ($urandom_range(0, 19) == 0);
            if (op == bht_pkg::OP_REMOVE && $urandom_range(0, 2) == 0)
                fn = '0;
            else if ($urandom_range(0, 7) == 0)
                fn = 8'($urandom);
            else
                fn = 8'($urandom_range(0, 5));
            if (op == bht_pkg::OP_REMOVE && $urandom_range(0, 2) == 0)
                cx = '0;
            else if ($urandom_range(0, 7) == 0)
                cx = 8'($urandom);
            else
                cx = 8'($urandom_range(0, 2));
            send_request(op, a, all, fn, cx);
        end
    endtask

    initial
    begin
        errors       = 0;
        stall_left   = 0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.operation        = '0;
        req_ch.address          = '0;
        req_ch.all_addresses    = 1'b0;
        req_ch.handler_function = '0;
        req_ch.handler_context  = '0;
        rsp_ch.ready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic();
        test_slots();
        test_remove();
        test_full_table();
        test_random(120);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (bht_pkg::TABLE_ENTRIES + 40) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
